[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, held off while rst_n is low.
`define CHK_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, but also evaluated during reset.
`define CHK_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/mte_pkg.sv]
// Package: word types, command record and constants of the MIDI track event encoder.
`timescale 1ns / 1ps

package mte_pkg;

    // Event codes carried in req_type
    typedef enum logic [1:0] {
        REQ_PROGRAM  = 2'd0,
        REQ_NOTE_ON  = 2'd1,
        REQ_NOTE_OFF = 2'd2,
        REQ_END      = 2'd3
    } req_kind_t;

    localparam int unsigned TICK_W = 28;

    // Status and meta bytes
    localparam logic [7:0] ST_PROGRAM  = 8'hC0;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] META_MARK   = 8'hFF;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] META_LEN0   = 8'h00;
    localparam logic [7:0] VLQ_CONT    = 8'h80;

    // Input word
    typedef struct packed {
        req_kind_t           req_type;
        logic [TICK_W-1:0]   event_tick;
        logic [3:0]          channel;
        logic [6:0]          first_arg;
        logic [6:0]          second_arg;
    } req_word_t;

    // Output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       order_error;
    } rsp_word_t;

    // Classified event handed from front to back
    typedef struct packed {
        logic              order_error;
        logic [TICK_W-1:0] delta;
        logic [1:0]        vlq_last;    // VLQ byte count minus one
        logic [7:0]        body0;
        logic [7:0]        body1;
        logic [7:0]        body2;
        logic              body_three;  // third body byte present
    } cmd_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

[hw/rtl/mte_front.sv]
// Front end: accepts events, checks tick order, computes the delta and classifies.
`timescale 1ns / 1ps

module mte_front
    import mte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_word_t   req,
    input  queue_stat_t q_stat,
    output logic        push,
    output cmd_t        push_cmd
);

    logic [TICK_W-1:0] prev_tick_reg;
    logic [TICK_W-1:0] prev_tick_next;
    logic              accept;
    logic              ordered;
    logic [TICK_W-1:0] delta;

    assign req_ready = !q_stat.full;
    assign accept    = req_valid && req_ready;
    assign push      = accept;

    // Order check and delta
    assign ordered = (req.event_tick >= prev_tick_reg);
    assign delta   = req.event_tick - prev_tick_reg;

    // Build the command record
    always_comb
    begin
        push_cmd             = '0;
        push_cmd.order_error = !ordered;
        push_cmd.delta       = delta;
        if (delta[27:21] != '0)
            push_cmd.vlq_last = 2'd3;
        else if (delta[20:14] != '0)
            push_cmd.vlq_last = 2'd2;
        else if (delta[13:7] != '0)
            push_cmd.vlq_last = 2'd1;
        else
            push_cmd.vlq_last = 2'd0;
        case (req.req_type)
            REQ_PROGRAM:
            begin
                push_cmd.body0      = ST_PROGRAM | {4'h0, req.channel};
                push_cmd.body1      = {1'b0, req.first_arg};
                push_cmd.body2      = '0;
                push_cmd.body_three = 1'b0;
            end
            REQ_NOTE_ON:
            begin
                push_cmd.body0      = ST_NOTE_ON | {4'h0, req.channel};
                push_cmd.body1      = {1'b0, req.first_arg};
                push_cmd.body2      = {1'b0, req.second_arg};
                push_cmd.body_three = 1'b1;
            end
            REQ_NOTE_OFF:
            begin
                push_cmd.body0      = ST_NOTE_OFF | {4'h0, req.channel};
                push_cmd.body1      = {1'b0, req.first_arg};
                push_cmd.body2      = {1'b0, req.second_arg};
                push_cmd.body_three = 1'b1;
            end
            default:
            begin
                push_cmd.body0      = META_MARK;
                push_cmd.body1      = META_EOT;
                push_cmd.body2      = META_LEN0;
                push_cmd.body_three = 1'b1;
            end
        endcase
    end

    // Previous tick: follows ordered events, cleared by end of track
    always_comb
    begin
        prev_tick_next = prev_tick_reg;
        if (accept && ordered)
        begin
            if (req.req_type == REQ_END)
                prev_tick_next = '0;
            else
                prev_tick_next = req.event_tick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_tick_reg <= '0;
        else
            prev_tick_reg <= prev_tick_next;
    end

endmodule

[hw/rtl/mte_queue.sv]
// Short command queue between front end and byte serializer.
`timescale 1ns / 1ps

module mte_queue
    import mte_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cmd_t        push_cmd,
    input  logic        pop,
    output cmd_t        head_cmd,
    output queue_stat_t q_stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    cmd_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_cmd     = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[hw/rtl/mte_back.sv]
// Back end: serializes one queued command into VLQ delta and body bytes, or a lone zero byte on an order error.
`timescale 1ns / 1ps

module mte_back
    import mte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head_cmd,
    input  queue_stat_t q_stat,
    output logic        pop,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_word_t   rsp
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    rsp_word_t  word_reg, word_next;
    logic       load;
    logic [2:0] last_idx;
    logic       is_last;
    logic [1:0] grp;
    logic [1:0] body_idx;
    logic [6:0] grp_bits;
    logic [7:0] cur_byte;

    assign rsp_valid = valid_reg;
    assign rsp       = word_reg;

    // A command is queued and the output register is free or being drained this cycle
    assign load = !q_stat.empty && (!valid_reg || rsp_ready);

    // Index of the final word of this command
    assign last_idx = head_cmd.order_error ? 3'd0 :
                      ({1'b0, head_cmd.vlq_last} + 3'd2 + {2'b00, head_cmd.body_three});
    assign is_last  = (idx_reg == last_idx);

    // Byte selection: VLQ groups most significant first, then body
    assign grp      = head_cmd.vlq_last - idx_reg[1:0];
    assign body_idx = 2'(idx_reg - {1'b0, head_cmd.vlq_last} - 3'd1);

    always_comb
    begin
        case (grp)
            2'd0:    grp_bits = head_cmd.delta[6:0];
            2'd1:    grp_bits = head_cmd.delta[13:7];
            2'd2:    grp_bits = head_cmd.delta[20:14];
            default: grp_bits = head_cmd.delta[27:21];
        endcase
    end

    always_comb
    begin
        if (idx_reg <= {1'b0, head_cmd.vlq_last})
            cur_byte = ((grp != 2'd0) ? VLQ_CONT : 8'h00) | {1'b0, grp_bits};
        else
        begin
            case (body_idx)
                2'd0:    cur_byte = head_cmd.body0;
                2'd1:    cur_byte = head_cmd.body1;
                default: cur_byte = head_cmd.body2;
            endcase
        end
    end

    // Next word, index and valid
    always_comb
    begin
        word_next  = word_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next            = 1'b1;
            word_next.order_error = head_cmd.order_error;
            word_next.last_byte   = is_last;
            word_next.out_byte    = head_cmd.order_error ? 8'h00 : cur_byte;
            if (is_last)
            begin
                pop      = 1'b1;
                idx_next = '0;
            end
            else
                idx_next = idx_reg + 1'b1;
        end
        else if (rsp_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

[hw/rtl/midi_track_event_encoder_top.sv]
// rsp_valid rises after an accepted event passes the queue count and output valid registers (queue empty, output free).
// One output word per cycle while rsp_ready is high; an event gives 1 to 7 words (VLQ bytes + body).
// Byte rate is set by the single-word output register of the serializer.
// Front accepts one event per cycle while the command queue has room.
// Reset (rst_n, async, active low) clears previous tick, queue and output valid.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module midi_track_event_encoder_top
    import mte_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    queue_stat_t q_stat;
    logic        push;
    logic        pop;
    cmd_t        push_cmd;
    cmd_t        head_cmd;
    logic        err_word_ok;

    mte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    mte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    mte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_stat    (q_stat),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Error word shape: lone zero byte marked last
    assign err_word_ok = rsp.last_byte && (rsp.out_byte == 8'h00);

    // Checks
    `CHK_CLK(a_err_word, (rsp_valid && rsp.order_error) |-> err_word_ok, "bad error word")
    `CHK_CLK(a_mid_event, (rsp_valid && rsp_ready && !rsp.last_byte) |=> rsp_valid, "gap in event")
    `CHK_CLK(a_ready_full, req_ready == !q_stat.full, "front ready must track queue space")
    `CHK_CLK(a_pop_nonempty, pop |-> !q_stat.empty, "pop from empty queue")

endmodule
